### hdl/bmpq_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bmpq_pkg
// Types and codes shared by the bounded max-priority queue modules.
// ----------------------------------------------------------------------------
package bmpq_pkg;

    localparam logic FUNC_PUSH = 1'b0;
    localparam logic FUNC_POP  = 1'b1;

    typedef struct packed {
        logic               func;
        logic [15:0]        entry_tag;
        logic signed [15:0] entry_priority;
    } in_item_t;

    typedef struct packed {
        logic [15:0]        top_tag;
        logic signed [15:0] top_priority;
        logic [4:0]         count;
        logic               is_empty;
        logic               is_full;
        logic               rejected;
    } out_item_t;

    typedef struct packed {
        logic [15:0]        tag;
        logic signed [15:0] prio;
    } entry_t;

    typedef struct packed {
        logic clear;
        logic take;
    } scan_ctl_t;

endpackage
`default_nettype wire

### hdl/bmpq_mem.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bmpq_mem
// Slot storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module bmpq_mem #(
    parameter int DEPTH  = 16,
    parameter int IDX_W  = 4
) (
    input  wire logic            aclk,
    input  wire logic            we,
    input  wire logic [IDX_W-1:0] waddr,
    input  wire bmpq_pkg::entry_t wdata,
    input  wire logic            re,
    input  wire logic [IDX_W-1:0] raddr,
    output bmpq_pkg::entry_t     rdata
);

    bmpq_pkg::entry_t mem [DEPTH];
    bmpq_pkg::entry_t rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

### hdl/bmpq_scan.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bmpq_scan
// Running maximum over slots streamed from memory; ties go to later slots.
// ----------------------------------------------------------------------------
module bmpq_scan #(
    parameter int IDX_W = 4
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire bmpq_pkg::scan_ctl_t ctl,
    input  wire logic [IDX_W-1:0]  idx,
    input  wire bmpq_pkg::entry_t  rdata,
    output logic [IDX_W-1:0]       best_idx,
    output bmpq_pkg::entry_t       best
);

    logic [IDX_W-1:0] best_idx_reg;
    logic [IDX_W-1:0] best_idx_next;
    bmpq_pkg::entry_t best_reg;
    bmpq_pkg::entry_t best_next;
    logic             win;

    assign win = ctl.take && ((idx == '0) || (best_reg.prio <= rdata.prio));

    always_comb begin
        best_idx_next = best_idx_reg;
        best_next     = best_reg;
        if (ctl.clear) begin
            best_idx_next = '0;
        end else if (win) begin
            best_idx_next = idx;
            best_next     = rdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            best_idx_reg <= '0;
        end else begin
            best_idx_reg <= best_idx_next;
        end
        best_reg <= best_next;
    end

    assign best_idx = best_idx_reg;
    assign best     = best_reg;

endmodule
`default_nettype wire

### hdl/bounded_max_priority_queue_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bounded_max_priority_queue_unit
// Bounded max-priority queue over DEPTH slots held in a synchronous memory.
// ----------------------------------------------------------------------------
// Input channel s_*: one transaction is one push (func 0) or pop (func 1).
// Output channel m_*: exactly one result transaction per input transaction,
// carrying top tag/priority, count, empty, full and the rejected flag.
// A push writes the next free slot; a pop reads the last slot and writes it
// over the top slot. Then the read port walks slots 0..count-1 while a
// running compare tracks the top (ties to the higher slot).
// A push goes from the scan state to the result state; a pop passes through
// POP_RD and POP_WR before the scan. Rejected operations go straight to the
// result state. The scan reads one slot at a time over the single memory
// read port.
// One transaction is in work at a time; s_ready is high only when idle.
// The result sits in an output register; if m_ready is low the block holds
// it and can take the next input transaction, but stalls before the next
// result is written. Reset (aresetn low, synchronous) empties the queue.
// ----------------------------------------------------------------------------
module bounded_max_priority_queue_unit #(
    parameter int DEPTH = 16
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire bmpq_pkg::in_item_t   s_item,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output bmpq_pkg::out_item_t       m_item
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_POP_RD = 3'd1;
    localparam logic [2:0] ST_POP_WR = 3'd2;
    localparam logic [2:0] ST_SCAN   = 3'd3;
    localparam logic [2:0] ST_RESULT = 3'd4;

    logic [2:0]       state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] issue_reg, issue_next;
    logic             rd_vld_reg, rd_vld_next;
    logic [IDX_W-1:0] rd_idx_reg, rd_idx_next;
    logic             rej_reg, rej_next;
    logic             m_valid_reg, m_valid_next;
    bmpq_pkg::out_item_t out_reg, out_next;

    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    bmpq_pkg::entry_t mem_wdata;
    logic             mem_re;
    logic [IDX_W-1:0] mem_raddr;
    bmpq_pkg::entry_t mem_rdata;

    bmpq_pkg::scan_ctl_t scan_ctl;
    logic [IDX_W-1:0]    best_idx;
    bmpq_pkg::entry_t    best;

    logic accept;
    logic is_full;
    logic is_empty;
    logic [CNT_W-1:0] last;

    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign is_full  = (count_reg == CNT_W'(DEPTH));
    assign is_empty = (count_reg == '0);
    assign last     = count_reg - CNT_W'(1);

    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        issue_next   = issue_reg;
        rd_vld_next  = 1'b0;
        rd_idx_next  = rd_idx_reg;
        rej_next     = rej_reg;
        m_valid_next = m_valid_reg && !m_ready;
        out_next     = out_reg;
        mem_we       = 1'b0;
        mem_waddr    = count_reg[IDX_W-1:0];
        mem_wdata.tag  = s_item.entry_tag;
        mem_wdata.prio = s_item.entry_priority;
        mem_re       = 1'b0;
        mem_raddr    = issue_reg[IDX_W-1:0];
        scan_ctl.clear = 1'b0;
        scan_ctl.take  = rd_vld_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    rej_next = 1'b0;
                    if (s_item.func == bmpq_pkg::FUNC_PUSH) begin
                        if (is_full) begin
                            rej_next   = 1'b1;
                            state_next = ST_RESULT;
                        end else begin
                            mem_we         = 1'b1;
                            count_next     = count_reg + CNT_W'(1);
                            issue_next     = '0;
                            scan_ctl.clear = 1'b1;
                            state_next     = ST_SCAN;
                        end
                    end else begin
                        if (is_empty) begin
                            rej_next   = 1'b1;
                            state_next = ST_RESULT;
                        end else begin
                            mem_re     = 1'b1;
                            mem_raddr  = last[IDX_W-1:0];
                            state_next = ST_POP_RD;
                        end
                    end
                end
            end
            ST_POP_RD: begin
                state_next = ST_POP_WR;
            end
            ST_POP_WR: begin
                mem_we         = 1'b1;
                mem_waddr      = best_idx;
                mem_wdata      = mem_rdata;
                count_next     = last;
                issue_next     = '0;
                scan_ctl.clear = 1'b1;
                state_next     = ST_SCAN;
            end
            ST_SCAN: begin
                if (issue_reg < count_reg) begin
                    mem_re      = 1'b1;
                    rd_vld_next = 1'b1;
                    rd_idx_next = issue_reg[IDX_W-1:0];
                    issue_next  = issue_reg + CNT_W'(1);
                end else if (!rd_vld_reg) begin
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT: begin
                if (!m_valid_reg || m_ready) begin
                    out_next.top_tag      = is_empty ? 16'd0 : best.tag;
                    out_next.top_priority = is_empty ? 16'sd0 : best.prio;
                    out_next.count        = 5'(count_reg);
                    out_next.is_empty     = is_empty;
                    out_next.is_full      = is_full;
                    out_next.rejected     = rej_reg;
                    m_valid_next          = 1'b1;
                    state_next            = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            issue_reg   <= '0;
            rd_vld_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            issue_reg   <= issue_next;
            rd_vld_reg  <= rd_vld_next;
            m_valid_reg <= m_valid_next;
        end
        rd_idx_reg <= rd_idx_next;
        rej_reg    <= rej_next;
        out_reg    <= out_next;
    end

    assign m_valid = m_valid_reg;
    assign m_item  = out_reg;

    bmpq_mem #(
        .DEPTH (DEPTH),
        .IDX_W (IDX_W)
    ) u_mem (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    bmpq_scan #(
        .IDX_W (IDX_W)
    ) u_scan (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctl      (scan_ctl),
        .idx      (rd_idx_reg),
        .rdata    (mem_rdata),
        .best_idx (best_idx),
        .best     (best)
    );

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("count above depth");

    a_no_write_in_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN) |-> !mem_we)
        else $error("memory write during scan");

    a_top_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RESULT && count_reg != '0) |-> (CNT_W'(best_idx) < count_reg))
        else $error("top slot outside occupied range");

    a_push_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_item.func == bmpq_pkg::FUNC_PUSH && !is_full)
        |=> (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("push did not grow count");
`endif

endmodule
`default_nettype wire

### tb/bmpq_result_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bmpq_result_checker
// Watches both channels of the priority queue and keeps its own copy of the
// slots, count and top index. Each accepted operation is applied to that
// copy to produce the expected result. Each accepted result is compared,
// field by field, against the oldest expected result still outstanding.
// ----------------------------------------------------------------------------
module bmpq_result_checker #(
    parameter int DEPTH = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    input  logic                s_ready,
    input  bmpq_pkg::in_item_t  s_item,
    input  logic                m_valid,
    input  logic                m_ready,
    input  bmpq_pkg::out_item_t m_item,
    output int unsigned         fail_count,
    output int unsigned         open_count
);

    logic [15:0]         slot_tag  [DEPTH];
    logic signed [15:0]  slot_prio [DEPTH];
    int unsigned         held;
    int unsigned         top_slot;
    bmpq_pkg::out_item_t expected_results [$];

    initial begin
        fail_count = 0;
        open_count = 0;
        held       = 0;
        top_slot   = 0;
    end

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        fail_count++;
    endtask

    // highest priority wins, ties go to the higher slot
    function automatic void find_top();
        int unsigned best;
        best = 0;
        for (int unsigned i = 0; i < held; i++) begin
            if (slot_prio[best] <= slot_prio[i])
                best = i;
        end
        top_slot = best;
    endfunction

    function automatic bmpq_pkg::out_item_t apply_queue_op(input bmpq_pkg::in_item_t op);
        bmpq_pkg::out_item_t res;
        res = '0;
        if (op.func == bmpq_pkg::FUNC_PUSH) begin
            if (held >= DEPTH) begin
                res.rejected = 1'b1;
            end else begin
                slot_tag[held]  = op.entry_tag;
                slot_prio[held] = op.entry_priority;
                held++;
                find_top();
            end
        end else begin
            if (held == 0) begin
                res.rejected = 1'b1;
            end else begin
                slot_tag[top_slot]  = slot_tag[held - 1];
                slot_prio[top_slot] = slot_prio[held - 1];
                held--;
                find_top();
            end
        end
        if (held != 0) begin
            res.top_tag      = slot_tag[top_slot];
            res.top_priority = slot_prio[top_slot];
        end
        res.count    = 5'(held);
        res.is_empty = (held == 0);
        res.is_full  = (held == DEPTH);
        return res;
    endfunction

    task automatic compare_result(input bmpq_pkg::out_item_t got);
        bmpq_pkg::out_item_t want;
        if (expected_results.size() == 0) begin
            report_mismatch($sformatf("result with no transaction outstanding: tag %h prio %0d",
                                      got.top_tag, got.top_priority));
            return;
        end
        want = expected_results.pop_front();
        if (got.top_tag !== want.top_tag)
            report_mismatch($sformatf("top_tag %h, expected %h", got.top_tag, want.top_tag));
        if (got.top_priority !== want.top_priority)
            report_mismatch($sformatf("top_priority %0d, expected %0d",
                                      got.top_priority, want.top_priority));
        if (got.count !== want.count)
            report_mismatch($sformatf("count %0d, expected %0d", got.count, want.count));
        if (got.is_empty !== want.is_empty)
            report_mismatch($sformatf("is_empty %b, expected %b", got.is_empty, want.is_empty));
        if (got.is_full !== want.is_full)
            report_mismatch($sformatf("is_full %b, expected %b", got.is_full, want.is_full));
        if (got.rejected !== want.rejected)
            report_mismatch($sformatf("rejected %b, expected %b", got.rejected, want.rejected));
    endtask

    // results are retired before new operations: a result never shares its
    // edge with the transaction that caused it
    always @(posedge aclk) begin
        if (!aresetn) begin
            held     = 0;
            top_slot = 0;
            expected_results.delete();
        end else begin
            if (m_valid && m_ready)
                compare_result(m_item);
            if (s_valid && s_ready)
                expected_results.push_back(apply_queue_op(s_item));
        end
        open_count = expected_results.size();
    end

endmodule

### tb/bounded_max_priority_queue_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bounded_max_priority_queue_unit_tb
// Drives push and pop transactions into the priority queue: a directed
// opening over empty pops, extreme priorities and ties, then random runs
// that lean toward filling, draining or holding the queue so that full and
// empty are hit often. Both channels pause at random. Results are checked by
// bmpq_result_checker.
// ----------------------------------------------------------------------------
module bounded_max_priority_queue_unit_tb;

    localparam int DEPTH       = 16;
    localparam int N_OPS       = 1750;
    localparam int CYCLE_LIMIT = 400000;

    logic                aclk;
    logic                aresetn;
    logic                s_valid;
    logic                s_ready;
    bmpq_pkg::in_item_t  s_item;
    logic                m_valid;
    logic                m_ready;
    bmpq_pkg::out_item_t m_item;
    logic                s_taken;
    logic                pace_on;
    int unsigned         fail_count;
    int unsigned         open_count;
    int unsigned         cycle_count = 0;
    int unsigned         ops_sent = 0;

    bounded_max_priority_queue_unit #(
        .DEPTH(DEPTH)
    ) dut (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_item (s_item),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_item (m_item)
    );

    bmpq_result_checker #(
        .DEPTH(DEPTH)
    ) result_check (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_item    (s_item),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item),
        .fail_count(fail_count),
        .open_count(open_count)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    always @(posedge aclk) s_taken <= aresetn && s_valid && s_ready;

    always @(negedge aclk) m_ready <= !pace_on || ($urandom_range(0, 99) >= 7);

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("bounded_max_priority_queue_unit verification failed");
            $finish;
        end
    end

    // narrow values make ties common
    function automatic logic [15:0] pick_priority();
        int unsigned sel;
        sel = $urandom_range(0, 99);
        if (sel < 40)
            return 16'($urandom_range(0, 4) - 2);
        if (sel < 50) begin
            case ($urandom_range(0, 3))
                0:       return 16'h8000;
                1:       return 16'h7FFF;
                2:       return 16'hFFFF;
                default: return 16'h0000;
            endcase
        end
        return 16'($urandom);
    endfunction

    task automatic send_op(input logic func, input logic [15:0] tag, input logic [15:0] prio);
        while (pace_on && $urandom_range(0, 99) < 7) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_item  <= '{func: func, entry_tag: tag, entry_priority: prio};
        do @(negedge aclk); while (!s_taken);
        ops_sent++;
    endtask

    initial begin
        int unsigned pop_pct;
        int unsigned run_len;
        logic        func;

        aresetn = 1'b0;
        s_valid = 1'b0;
        s_item  = '0;
        m_ready = 1'b0;
        pace_on = 1'b1;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        send_op(bmpq_pkg::FUNC_POP,  16'h1234, 16'h0000);   // pop on empty queue
        send_op(bmpq_pkg::FUNC_PUSH, 16'hFFFF, 16'h7FFF);
        send_op(bmpq_pkg::FUNC_POP,  16'h0000, 16'hFFFF);   // last entry leaves
        send_op(bmpq_pkg::FUNC_PUSH, 16'h0000, 16'h8000);
        send_op(bmpq_pkg::FUNC_PUSH, 16'h0001, 16'h8000);   // tie, higher slot wins
        send_op(bmpq_pkg::FUNC_PUSH, 16'hA5A5, 16'hFFFF);
        send_op(bmpq_pkg::FUNC_PUSH, 16'h5A5A, 16'h0000);
        send_op(bmpq_pkg::FUNC_PUSH, 16'h0002, 16'h7FFF);
        send_op(bmpq_pkg::FUNC_PUSH, 16'h0003, 16'h7FFF);
        send_op(bmpq_pkg::FUNC_PUSH, 16'h8000, 16'h0001);
        repeat (8) send_op(bmpq_pkg::FUNC_POP, 16'($urandom), 16'($urandom));
        send_op(bmpq_pkg::FUNC_POP,  16'hFFFF, 16'h7FFF);   // pop on empty queue again

        while (ops_sent < N_OPS) begin
            case ($urandom_range(0, 2))
                0:       pop_pct = 15;
                1:       pop_pct = 85;
                default: pop_pct = 50;
            endcase
            run_len = $urandom_range(8, 60);
            repeat (run_len) begin
                pace_on <= !(ops_sent >= 700 && ops_sent < 1000);
                func = ($urandom_range(0, 99) < pop_pct) ? bmpq_pkg::FUNC_POP
                                                          : bmpq_pkg::FUNC_PUSH;
                send_op(func, 16'($urandom), pick_priority());
            end
        end
        s_valid <= 1'b0;

        while (open_count != 0) @(negedge aclk);
        repeat (DEPTH + 8) @(negedge aclk);
        if (fail_count == 0 && open_count == 0)
            $display("bounded_max_priority_queue_unit verification clean");
        else
            $display("bounded_max_priority_queue_unit verification failed");
        $finish;
    end

endmodule
